// ===== hdl/rgl_pkg.sv =====
package rgl_pkg;

  // Default sizes of the grouping memories
  localparam int RGL_MAX_NONTERMS = 256;
  localparam int RGL_MAX_RULES    = 1024;

  // Field widths fixed by the item formats
  localparam int SYM_W      = 10;
  localparam int TOK_W      = 10;
  localparam int NC_W       = 9;
  localparam int RULE_W     = 10;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 10;

  // Item opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TOKEN_COUNT   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_NONTERM_COUNT = 1'b1;

endpackage

// ===== hdl/rgl_if.sv =====
interface rgl_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [rgl_pkg::SYM_W-1:0]  lhs_symbol;

  modport source (output valid, output op, output lhs_symbol, input ready);
  modport sink   (input valid, input op, input lhs_symbol, output ready);
endinterface

interface rgl_out_if;
  logic                       valid;
  logic                       ready;
  logic [rgl_pkg::SYM_W-1:0]  nonterminal;
  logic [rgl_pkg::RULE_W-1:0] rule_number;
  logic                       end_marker;
  logic                       last;
  logic                       error;

  modport source (output valid, output nonterminal, output rule_number,
                  output end_marker, output last, output error, input ready);
  modport sink   (input valid, input nonterminal, input rule_number,
                  input end_marker, input last, input error, output ready);
endinterface

interface rgl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rgl_pkg::CFG_ADDR_W-1:0] addr;
  logic [rgl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== hdl/rgl_ram.sv =====
module rgl_ram #(
  parameter int DEPTH = rgl_pkg::RGL_MAX_RULES,
  parameter int WIDTH = 10,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read strobe
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/rule_grouping_by_lhs.sv =====
// Rule grouping by left-hand nonterminal.
//
// Channels: in_ch takes items with op = append (lhs_symbol gives the rule's
// left-hand symbol) or op = read (fetch the next entry of the grouped list).
// Appends produce no result; each read produces exactly one item on out_ch.
// cfg_ch writes token_count (addr 0) and nonterm_count (addr 1); it is always
// ready and must only be used while the block is idle.
//
// Timing: an item is accepted in the idle state, the head/tail memory and the
// next-pointer memory are read at that edge, and the update state does the
// update and, for a read, loads the output register. The synchronous memory
// read is followed by the write-back, so no new item is taken until the last
// has left the update state; a read result shows on out_ch the cycle after.
//
// Stalls: a finished result waits in the output register while new appends
// are still taken; a read that finds the output register full holds in its
// update cycle until the receiver takes the waiting item.
// Reset: configuration returns to token_count 0 and nonterm_count 1, the list
// is empty and the error flag is clear. The final end marker of a drain also
// empties the list and clears the error flag.
module rule_grouping_by_lhs #(
  parameter int MAX_NONTERMS = rgl_pkg::RGL_MAX_NONTERMS,
  parameter int MAX_RULES    = rgl_pkg::RGL_MAX_RULES
) (
  input  logic       clk,
  input  logic       rst_n,
  rgl_in_if.sink     in_ch,
  rgl_out_if.source  out_ch,
  rgl_cfg_if.sink    cfg_ch
);

  localparam int NW   = (MAX_NONTERMS > 1) ? $clog2(MAX_NONTERMS) : 1;
  localparam int RW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNTW = $clog2(MAX_RULES + 1);
  localparam int EW   = $clog2(MAX_NONTERMS + 1);
  // Common width for symbol arithmetic and nonterminal compares
  localparam int CW   = (EW > rgl_pkg::SYM_W) ? EW : rgl_pkg::SYM_W;
  localparam int RXW  = (RW > rgl_pkg::RULE_W) ? RW : rgl_pkg::RULE_W;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  // Control and configuration registers
  state_t                        state_r, state_nxt;
  logic [rgl_pkg::TOK_W-1:0]     tok_r, tok_nxt;
  logic [rgl_pkg::NC_W-1:0]      nc_r, nc_nxt;
  logic [MAX_NONTERMS-1:0]       hv_r, hv_nxt;
  logic [CNTW-1:0]               rule_count_r, rule_count_nxt;
  logic [NW-1:0]                 rn_r, rn_nxt;
  logic [RW-1:0]                 rr_r, rr_nxt;
  logic                          in_list_r, in_list_nxt;
  logic                          err_r, err_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Item and result payload registers
  logic                          op_r, op_nxt;
  logic                          ok_r, ok_nxt;
  logic [NW-1:0]                 k_r, k_nxt;
  logic [rgl_pkg::SYM_W-1:0]     out_nt_r, out_nt_nxt;
  logic [rgl_pkg::RULE_W-1:0]    out_rule_r, out_rule_nxt;
  logic                          out_end_r, out_end_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_err_r, out_err_nxt;

  // Memory ports
  logic                          nt_we;
  logic [NW-1:0]                 nt_raddr;
  logic [2*RW-1:0]               nt_wdata, nt_rdata;
  logic                          nx_we;
  logic [RW-1:0]                 nx_rdata;
  logic [RW-1:0]                 head_rd, tail_rd;

  // Datapath
  logic                          accept;
  logic [CW-1:0]                 tok_x, sym_x, diff, eff, nc_x, k_x, nt_sum;
  logic                          sym_ok;
  logic                          hv_k, full, app_do, rd_go;
  logic [RW-1:0]                 new_rule, rd_rule;
  logic                          endm, k_last;
  logic [RXW-1:0]                rule_x;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  // Range check of the appended symbol, done at accept time
  assign tok_x  = CW'(tok_r);
  assign sym_x  = CW'(in_ch.lhs_symbol);
  assign diff   = sym_x - tok_x;
  assign nc_x   = CW'(nc_r);
  assign eff    = (nc_r == '0) ? CW'(1) :
                  ((nc_x > CW'(MAX_NONTERMS)) ? CW'(MAX_NONTERMS) : nc_x);
  assign sym_ok = (sym_x >= tok_x) && (diff < eff);

  // Appends address the head/tail entry of their nonterminal, reads the
  // entry of the nonterminal being drained
  assign nt_raddr = (in_ch.op == rgl_pkg::OP_APPEND) ? diff[NW-1:0] : rn_r;

  assign head_rd  = nt_rdata[2*RW-1:RW];
  assign tail_rd  = nt_rdata[RW-1:0];
  assign hv_k     = hv_r[k_r];
  assign full     = (rule_count_r >= CNTW'(MAX_RULES));
  assign new_rule = rule_count_r[RW-1:0];

  assign app_do = (state_r == ST_EXEC) && (op_r == rgl_pkg::OP_APPEND) && ok_r && !full;
  assign rd_go  = (state_r == ST_EXEC) && (op_r == rgl_pkg::OP_READ) &&
                  (!out_valid_r || out_ch.ready);

  // Append: keep the head if the chain exists, always move the tail
  assign nt_we    = app_do;
  assign nt_wdata = {(hv_k ? head_rd : new_rule), new_rule};
  assign nx_we    = app_do && hv_k;

  rgl_ram #(.DEPTH(MAX_NONTERMS), .WIDTH(2 * RW)) u_nt_mem (
    .clk   (clk),
    .we    (nt_we),
    .waddr (k_r),
    .wdata (nt_wdata),
    .re    (accept),
    .raddr (nt_raddr),
    .rdata (nt_rdata)
  );

  rgl_ram #(.DEPTH(MAX_RULES), .WIDTH(RW)) u_next_mem (
    .clk   (clk),
    .we    (nx_we),
    .waddr (tail_rd),
    .wdata (new_rule),
    .re    (accept),
    .raddr (rr_r),
    .rdata (nx_rdata)
  );

  // Read walk: start at the head, follow next pointers, stop at the tail
  always_comb begin
    rd_rule = '0;
    endm    = 1'b0;
    if (!in_list_r) begin
      if (hv_k) begin
        rd_rule = head_rd;
      end else begin
        endm = 1'b1;
      end
    end else if (rr_r == tail_rd) begin
      endm = 1'b1;
    end else begin
      rd_rule = nx_rdata;
    end
  end

  assign k_x    = CW'(k_r);
  assign k_last = ((k_x + CW'(1)) >= eff);
  assign nt_sum = tok_x + k_x;
  assign rule_x = RXW'(rd_rule);

  always_comb begin
    state_nxt      = state_r;
    tok_nxt        = tok_r;
    nc_nxt         = nc_r;
    hv_nxt         = hv_r;
    rule_count_nxt = rule_count_r;
    rn_nxt         = rn_r;
    rr_nxt         = rr_r;
    in_list_nxt    = in_list_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    op_nxt         = op_r;
    ok_nxt         = ok_r;
    k_nxt          = k_r;
    out_nt_nxt     = out_nt_r;
    out_rule_nxt   = out_rule_r;
    out_end_nxt    = out_end_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;

    if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        rgl_pkg::REG_TOKEN_COUNT:   tok_nxt = cfg_ch.data;
        rgl_pkg::REG_NONTERM_COUNT: nc_nxt  = cfg_ch.data[rgl_pkg::NC_W-1:0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_ch.op;
          ok_nxt    = sym_ok;
          k_nxt     = (in_ch.op == rgl_pkg::OP_APPEND) ? diff[NW-1:0] : rn_r;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == rgl_pkg::OP_APPEND) begin
          if (app_do) begin
            hv_nxt[k_r]    = 1'b1;
            rule_count_nxt = rule_count_r + CNTW'(1);
          end else begin
            err_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end else if (rd_go) begin
          out_valid_nxt = 1'b1;
          out_nt_nxt    = nt_sum[rgl_pkg::SYM_W-1:0];
          out_rule_nxt  = rule_x[rgl_pkg::RULE_W-1:0];
          out_end_nxt   = endm;
          out_last_nxt  = endm && k_last;
          out_err_nxt   = err_r;
          if (endm) begin
            in_list_nxt = 1'b0;
            if (k_last) begin
              // Drain done: empty the list for the next grammar
              hv_nxt         = '0;
              rule_count_nxt = '0;
              rn_nxt         = '0;
              rr_nxt         = '0;
              err_nxt        = 1'b0;
            end else begin
              rn_nxt = k_r + NW'(1);
            end
          end else begin
            rr_nxt      = rd_rule;
            in_list_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tok_r        <= '0;
      nc_r         <= rgl_pkg::NC_W'(1);
      hv_r         <= '0;
      rule_count_r <= '0;
      rn_r         <= '0;
      rr_r         <= '0;
      in_list_r    <= 1'b0;
      err_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tok_r        <= tok_nxt;
      nc_r         <= nc_nxt;
      hv_r         <= hv_nxt;
      rule_count_r <= rule_count_nxt;
      rn_r         <= rn_nxt;
      rr_r         <= rr_nxt;
      in_list_r    <= in_list_nxt;
      err_r        <= err_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    ok_r       <= ok_nxt;
    k_r        <= k_nxt;
    out_nt_r   <= out_nt_nxt;
    out_rule_r <= out_rule_nxt;
    out_end_r  <= out_end_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.nonterminal = out_nt_r;
  assign out_ch.rule_number = out_rule_r;
  assign out_ch.end_marker  = out_end_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.error       = out_err_r;

  // The rule counter never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rule_count_r <= CNTW'(MAX_RULES))
    else $error("rule counter beyond capacity");

  // A list walk only runs on a nonterminal that has a chain
  a_walk_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_list_r |-> hv_r[rn_r])
    else $error("walking a nonterminal without rules");

  // Appends never stall in the update cycle
  a_append_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && op_r == rgl_pkg::OP_APPEND) |=> (state_r == ST_IDLE))
    else $error("append held in update cycle");

  // The final end marker leaves an empty list
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_go && endm && k_last) |=>
      (rule_count_r == '0 && !in_list_r && hv_r == '0 && !err_r))
    else $error("list not cleared after final marker");

endmodule
